// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/ebsd_pkg.sv
// ----------------------------------------------------------------------------
// ebsd_pkg
// shared constants and types of the escape byte-stuffing deframer
// ----------------------------------------------------------------------------
`default_nettype none

package ebsd_pkg;

   localparam int MaxPayload = 64;
   localparam int AddrW      = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
   localparam int CntW       = 7;
   localparam int ByteW      = 8;
   localparam int StatusW    = 3;
   localparam int CsrIndexW  = 2;
   localparam int RspDataW   = ((ByteW + CntW + 7) / 8) * 8;
   localparam int ReqDataW   = ByteW;

   // result status codes
   localparam logic [StatusW-1:0] StPayload     = 3'd0;
   localparam logic [StatusW-1:0] StEmpty       = 3'd1;
   localparam logic [StatusW-1:0] StBadEscape   = 3'd2;
   localparam logic [StatusW-1:0] StMissingEnd  = 3'd3;
   localparam logic [StatusW-1:0] StOverflow    = 3'd4;

   // configuration register indexes
   localparam logic [CsrIndexW-1:0] CsrStartCode  = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrEndCode    = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrEscapeCode = 2'd2;

   // reset values of the code registers
   localparam logic [ByteW-1:0] RstStartCode  = 8'd83;
   localparam logic [ByteW-1:0] RstEndCode    = 8'd69;
   localparam logic [ByteW-1:0] RstEscapeCode = 8'd92;

   // command from the receive parser to the transmit sequencer
   typedef struct packed {
      logic                valid;
      logic                drain;
      logic [StatusW-1:0]  status;
      logic [CntW-1:0]     length;
   } tx_cmd_type;

endpackage

`default_nettype wire

// File: src/ebsd_frame_ram.sv
// ----------------------------------------------------------------------------
// ebsd_frame_ram
// simple dual-port frame store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module ebsd_frame_ram #(
   parameter int DataW = 8,
   parameter int Depth = 64,
   localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AddrW-1:0] wr_addr,
   input  wire logic [DataW-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [DataW-1:0] rd_data
);

   logic [DataW-1:0] mem_ff [Depth];
   logic [DataW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: src/ebsd_rx_ctrl.sv
// ----------------------------------------------------------------------------
// ebsd_rx_ctrl
// receive parser: code registers, frame mode, byte count, store writes
// ----------------------------------------------------------------------------
`default_nettype none

module ebsd_rx_ctrl (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration writes
   input  wire logic                              csr_valid,
   input  wire logic [ebsd_pkg::CsrIndexW-1:0]    csr_index,
   input  wire logic [ebsd_pkg::ByteW-1:0]        csr_data,
   // accepted byte
   input  wire logic                              accept,
   input  wire logic [ebsd_pkg::ByteW-1:0]        rx_byte,
   input  wire logic                              resync,
   // frame store write port
   output logic                                   wr_en,
   output logic      [ebsd_pkg::AddrW-1:0]        wr_addr,
   output logic      [ebsd_pkg::ByteW-1:0]        wr_data,
   // command to the transmit sequencer
   output ebsd_pkg::tx_cmd_type                   cmd
);

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'b001,
      MODE_FRAME = 3'b010,
      MODE_ESC   = 3'b100
   } mode_type;

   mode_type                       mode_ff, mode_in, mode_eff;
   logic [ebsd_pkg::CntW-1:0]      count_ff, count_in, count_eff;
   logic [ebsd_pkg::ByteW-1:0]     start_code_ff, end_code_ff, escape_code_ff;
   logic                           store_req;
   logic                           is_start, is_end, is_esc;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_code_ff  <= ebsd_pkg::RstStartCode;
         end_code_ff    <= ebsd_pkg::RstEndCode;
         escape_code_ff <= ebsd_pkg::RstEscapeCode;
      end else if (csr_valid) begin
         case (csr_index)
            ebsd_pkg::CsrStartCode:  start_code_ff  <= csr_data;
            ebsd_pkg::CsrEndCode:    end_code_ff    <= csr_data;
            ebsd_pkg::CsrEscapeCode: escape_code_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign is_start = (rx_byte == start_code_ff);
   assign is_end   = (rx_byte == end_code_ff);
   assign is_esc   = (rx_byte == escape_code_ff);

   always_comb begin
      mode_eff  = resync ? MODE_IDLE : mode_ff;
      count_eff = resync ? '0 : count_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      store_req = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = count_eff[ebsd_pkg::AddrW-1:0];
      wr_data   = rx_byte;
      cmd       = '0;
      if (accept) begin
         mode_in  = mode_eff;
         count_in = count_eff;
         case (mode_eff)
            MODE_FRAME: begin
               if (is_esc) begin
                  mode_in = MODE_ESC;
               end else if (is_end) begin
                  mode_in   = MODE_IDLE;
                  count_in  = '0;
                  cmd.valid = 1'b1;
                  if (count_eff == '0) begin
                     cmd.status = ebsd_pkg::StEmpty;
                  end else begin
                     cmd.drain  = 1'b1;
                     cmd.status = ebsd_pkg::StPayload;
                     cmd.length = count_eff;
                  end
               end else if (is_start) begin
                  mode_in    = MODE_FRAME;
                  count_in   = '0;
                  cmd.valid  = 1'b1;
                  cmd.status = ebsd_pkg::StMissingEnd;
               end else begin
                  store_req = 1'b1;
               end
            end
            MODE_ESC: begin
               if (is_esc || is_end || is_start) begin
                  mode_in   = MODE_FRAME;
                  store_req = 1'b1;
               end else begin
                  mode_in    = MODE_IDLE;
                  count_in   = '0;
                  cmd.valid  = 1'b1;
                  cmd.status = ebsd_pkg::StBadEscape;
               end
            end
            default: begin
               // outside a frame, only the start code matters
               if (is_start) begin
                  mode_in  = MODE_FRAME;
                  count_in = '0;
               end
            end
         endcase
         if (store_req) begin
            if (count_eff >= ebsd_pkg::CntW'(ebsd_pkg::MaxPayload)) begin
               mode_in    = MODE_IDLE;
               count_in   = '0;
               cmd.valid  = 1'b1;
               cmd.status = ebsd_pkg::StOverflow;
            end else begin
               wr_en    = 1'b1;
               count_in = count_eff + ebsd_pkg::CntW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         count_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: src/ebsd_tx_seq.sv
// ----------------------------------------------------------------------------
// ebsd_tx_seq
// transmit sequencer: status results, frame store readout, output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ebsd_tx_seq (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ebsd_pkg::tx_cmd_type              cmd,
   output logic                                   busy,
   // frame store read port
   output logic                                   rd_en,
   output logic      [ebsd_pkg::AddrW-1:0]        rd_addr,
   input  wire logic [ebsd_pkg::ByteW-1:0]        rd_data,
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [ebsd_pkg::RspDataW-1:0]     rsp_tdata,
   output logic                                   rsp_tlast,
   output logic      [ebsd_pkg::StatusW-1:0]      rsp_tuser
);

   localparam int PadW = ebsd_pkg::RspDataW - ebsd_pkg::ByteW - ebsd_pkg::CntW;

   logic                            st_pend_ff, st_pend_in;
   logic [ebsd_pkg::StatusW-1:0]    st_code_ff;
   logic                            drn_act_ff, drn_act_in;
   logic [ebsd_pkg::CntW-1:0]       len_ff;
   logic [ebsd_pkg::CntW-1:0]       rd_idx_ff, rd_idx_in, rd_idx_inc;
   logic                            rd_pend_ff, rd_pend_in;
   logic                            rd_last_ff, rd_last_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ebsd_pkg::ByteW-1:0]      rsp_byte_ff;
   logic [ebsd_pkg::CntW-1:0]       rsp_len_ff;
   logic                            rsp_last_ff;
   logic [ebsd_pkg::StatusW-1:0]    rsp_status_ff;
   logic                            slot_free, load_st, load_rd;

   assign busy       = st_pend_ff | drn_act_ff | rd_pend_ff;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign load_st    = st_pend_ff && slot_free;
   assign load_rd    = rd_pend_ff && slot_free;
   assign rd_en      = drn_act_ff && (!rd_pend_ff || slot_free);
   assign rd_addr    = rd_idx_ff[ebsd_pkg::AddrW-1:0];
   assign rd_idx_inc = rd_idx_ff + ebsd_pkg::CntW'(1);

   always_comb begin
      st_pend_in   = st_pend_ff;
      drn_act_in   = drn_act_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = rd_pend_ff;
      rd_last_in   = rd_last_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_st) begin
         st_pend_in   = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (load_rd) begin
         rd_pend_in   = 1'b0;
         rsp_valid_in = 1'b1;
      end
      if (rd_en) begin
         rd_pend_in = 1'b1;
         rd_idx_in  = rd_idx_inc;
         rd_last_in = (rd_idx_inc == len_ff);
         if (rd_idx_inc == len_ff) begin
            drn_act_in = 1'b0;
         end
      end
      if (cmd.valid) begin
         if (cmd.drain) begin
            drn_act_in = 1'b1;
            rd_idx_in  = '0;
         end else begin
            st_pend_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_pend_ff   <= 1'b0;
         drn_act_ff   <= 1'b0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_idx_ff    <= '0;
         rd_last_ff   <= 1'b0;
      end else begin
         st_pend_ff   <= st_pend_in;
         drn_act_ff   <= drn_act_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_idx_ff    <= rd_idx_in;
         rd_last_ff   <= rd_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         st_code_ff <= cmd.status;
         len_ff     <= cmd.length;
      end
      if (load_st) begin
         rsp_byte_ff   <= '0;
         rsp_len_ff    <= '0;
         rsp_last_ff   <= 1'b1;
         rsp_status_ff <= st_code_ff;
      end else if (load_rd) begin
         rsp_byte_ff   <= rd_data;
         rsp_len_ff    <= len_ff;
         rsp_last_ff   <= rd_last_ff;
         rsp_status_ff <= ebsd_pkg::StPayload;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PadW{1'b0}}, rsp_len_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   // a new command only arrives when nothing is in flight
   `ASSERT_IMPL(a_cmd_when_idle, clock, reset, cmd.valid, !busy, "command while busy")
   // status and readout never overlap
   `ASSERT_IMPL(a_no_overlap, clock, reset, drn_act_ff, !st_pend_ff, "status during drain")
   // an issued read always leaves data waiting for the output register
   `ASSERT_NEXT(a_rd_pend, clock, reset, rd_en, rd_pend_ff, "read data lost")
   // final readout entry carries the last mark
   `ASSERT_NEXT(a_last_mark, clock, reset, rd_en && (rd_idx_inc == len_ff), rd_last_ff,
                "last entry not marked")

endmodule

`default_nettype wire

// File: src/escape_byte_stuffing_deframer_core.sv
// ----------------------------------------------------------------------------
// escape_byte_stuffing_deframer_core
// start/end/escape framed byte stream deframer with a 64-byte frame store
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  req_      in   req_tvalid/req_tready   tdata: rx_byte; tuser: resync
//  rsp_      out  rsp_tvalid/rsp_tready   tdata: payload_byte, frame_length;
//                                         tlast: last_in_run; tuser: status
//  csr_      in   csr_valid/csr_ready     csr_index, csr_data
//
//  a byte that gives no result leaves req_tready high; the next byte follows at once
//  a byte that gives a status result holds req_tready low until the status has
//  moved from the pending slot into the output register
//  an end code of an n-byte frame holds off input until its last entry is in the
//  output register; the frame store read port streams one entry per cycle into the
//  output register, stalled while rsp_tready is low; reset is synchronous, the frame
//  store has no clearing pass, only entries written in the current frame are read
// ----------------------------------------------------------------------------
`default_nettype none

module escape_byte_stuffing_deframer_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // byte stream in
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ebsd_pkg::ReqDataW-1:0]     req_tdata,  // [7:0] rx_byte
   input  wire logic                              req_tuser,  // [0] resync
   // result stream out
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic      [ebsd_pkg::RspDataW-1:0]     rsp_tdata,  // [7:0] payload_byte,
                                                              // [14:8] frame_length,
                                                              // [15] zero
   output logic                                   rsp_tlast,  // last_in_run
   output logic      [ebsd_pkg::StatusW-1:0]      rsp_tuser,  // [2:0] status
   // configuration writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ebsd_pkg::CsrIndexW-1:0]    csr_index,
   input  wire logic [ebsd_pkg::ByteW-1:0]        csr_data
);

   logic                          tx_busy;
   logic                          req_xfer;
   ebsd_pkg::tx_cmd_type          cmd;
   logic                          wr_en, rd_en;
   logic [ebsd_pkg::AddrW-1:0]    wr_addr, rd_addr;
   logic [ebsd_pkg::ByteW-1:0]    wr_data, rd_data;

   // register writes are always taken
   assign csr_ready  = 1'b1;

   // input waits only while a status or a frame readout is in flight
   assign req_tready = !tx_busy;
   assign req_xfer   = req_tvalid && req_tready;

   ebsd_rx_ctrl u_rx_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .accept    (req_xfer),
      .rx_byte   (req_tdata[ebsd_pkg::ByteW-1:0]),
      .resync    (req_tuser),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .cmd       (cmd)
   );

   // unescaped payload bytes of the current frame
   ebsd_frame_ram #(
      .DataW (ebsd_pkg::ByteW),
      .Depth (ebsd_pkg::MaxPayload)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // results: status items and frame readout through one output register
   ebsd_tx_seq u_tx_seq (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .busy       (tx_busy),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
